[rtl/dqr_pkg.sv]
// ----------------------------------------------------------------------------
// dqr_pkg
// Shared types and constants for the DNS query redirect responder.
// ----------------------------------------------------------------------------
package dqr_pkg;

  // Number of bytes in a DNS header.
  localparam int unsigned HdrBytes = 12;
  // Fixed part of the answer record, before the address octets.
  localparam int unsigned AnswerPrefixBytes = 12;
  // Whole answer record: the fixed part and four address octets.
  localparam int unsigned AnswerBytes = 16;
  // Default size limit of a response datagram.
  localparam int unsigned MaxPacketBytesDef = 512;
  // Address returned after reset (192.168.4.1).
  localparam logic [31:0] RedirectAddressRst = 32'hC0A8_0401;

  // Header byte positions that are modified on the way out.
  localparam logic [3:0] HdrFlagsHiIdx = 4'd2;
  localparam logic [3:0] HdrFlagsLoIdx = 4'd3;
  localparam logic [3:0] HdrAnCountLoIdx = 4'd7;
  // Bit set in both flag bytes (QR and RA).
  localparam logic [7:0] HdrFlagBit = 8'h80;
  // Last header index, abort item index and last answer record index.
  localparam logic [3:0] HdrLastIdx = 4'd11;
  localparam logic [3:0] HdrAbortIdx = 4'd12;
  localparam logic [3:0] AnswerLastIdx = 4'd15;

  // Name pointer to offset 12, type A, class IN, TTL 60, length 4.
  localparam logic [7:0] AnswerPrefix [AnswerPrefixBytes] = '{
    8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01,
    8'h00, 8'h00, 8'h00, 8'h3C, 8'h00, 8'h04
  };

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_NAME    = 4'b0010,
    PH_TRAILER = 4'b0100,
    PH_SWALLOW = 4'b1000
  } phase_e;

  // Burst sequencer state, one-hot.
  typedef enum logic [2:0] {
    BU_IDLE   = 3'b001,
    BU_HEADER = 3'b010,
    BU_ANSWER = 3'b100
  } burst_e;

  // Request from the parser to the reply emitter for one accepted byte.
  typedef struct packed {
    logic       single;     // emit one item now (data, last, abort)
    logic [7:0] data;       // byte to emit, also the byte to store
    logic       last;
    logic       abort;
    logic       start_hdr;  // start the header burst
    logic       hdr_abort;  // header burst ends in an abort item
    logic       start_ans;  // start the answer burst after the single item
    logic       store_we;   // write data into the header store
    logic [3:0] store_idx;
  } emit_req_t;

endpackage

[rtl/dqr_emitter.sv]
// ----------------------------------------------------------------------------
// dqr_emitter
// Output register, header store and burst sequencer for the reply stream.
// ----------------------------------------------------------------------------
module dqr_emitter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dqr_pkg::emit_req_t req_i,         // valid only when accepted
  input  logic [31:0]       redirect_address_i,
  output logic              ready_o,       // a new request can be taken
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,  // [7:0] reply_byte
  output logic              m_axis_tlast,  // reply_last
  output logic [0:0]        m_axis_tuser   // [0] reply_abort
);
  import dqr_pkg::*;

  logic [7:0] store_q [HdrBytes];

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_data_q, out_data_d;
  logic       out_last_q, out_last_d;
  logic       out_abort_q, out_abort_d;

  burst_e     burst_q, burst_d;
  logic [3:0] idx_q, idx_d;
  logic       hdr_abort_q, hdr_abort_d;

  logic       out_free;
  logic [3:0] store_rd_idx;
  logic [7:0] hdr_byte;
  logic [7:0] ans_byte;

  assign out_free = !out_valid_q || m_axis_tready;
  assign ready_o  = out_free && (burst_q == BU_IDLE);

  // Header store, written one byte per accepted header byte.
  always_ff @(posedge clk_i) begin
    if (req_i.store_we) begin
      store_q[req_i.store_idx] <= req_i.data;
    end
  end

  // Header byte for the current burst position, with QR, RA and ANCOUNT fixed.
  assign store_rd_idx = (idx_q <= HdrLastIdx) ? idx_q : '0;

  always_comb begin
    hdr_byte = store_q[store_rd_idx];
    if (idx_q == HdrFlagsHiIdx || idx_q == HdrFlagsLoIdx) begin
      hdr_byte = hdr_byte | HdrFlagBit;
    end
    if (idx_q == HdrAnCountLoIdx) begin
      hdr_byte = 8'h01;
    end
  end

  // Answer record byte: fixed prefix, then the address, first octet first.
  always_comb begin
    if (idx_q < 4'(AnswerPrefixBytes)) begin
      ans_byte = AnswerPrefix[idx_q];
    end else begin
      case (idx_q[1:0])
        2'd0:    ans_byte = redirect_address_i[31:24];
        2'd1:    ans_byte = redirect_address_i[23:16];
        2'd2:    ans_byte = redirect_address_i[15:8];
        default: ans_byte = redirect_address_i[7:0];
      endcase
    end
  end

  // Next state of the output register and the burst sequencer.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_abort_d = out_abort_q;
    burst_d     = burst_q;
    idx_d       = idx_q;
    hdr_abort_d = hdr_abort_q;

    if (out_free) begin
      out_valid_d = 1'b0;
    end

    if (req_i.single) begin
      out_valid_d = 1'b1;
      out_data_d  = req_i.data;
      out_last_d  = req_i.last;
      out_abort_d = req_i.abort;
    end

    if (req_i.start_hdr) begin
      burst_d     = BU_HEADER;
      idx_d       = '0;
      hdr_abort_d = req_i.hdr_abort;
    end else if (req_i.start_ans) begin
      burst_d = BU_ANSWER;
      idx_d   = '0;
    end else if (out_free) begin
      case (burst_q)
        BU_HEADER: begin
          out_valid_d = 1'b1;
          if (idx_q == HdrAbortIdx) begin
            out_data_d  = '0;
            out_last_d  = 1'b1;
            out_abort_d = 1'b1;
          end else begin
            out_data_d  = hdr_byte;
            out_last_d  = 1'b0;
            out_abort_d = 1'b0;
          end
          idx_d = idx_q + 4'd1;
          if (idx_q == HdrAbortIdx || (idx_q == HdrLastIdx && !hdr_abort_q)) begin
            burst_d = BU_IDLE;
          end
        end
        BU_ANSWER: begin
          out_valid_d = 1'b1;
          out_data_d  = ans_byte;
          out_last_d  = (idx_q == AnswerLastIdx);
          out_abort_d = 1'b0;
          idx_d       = idx_q + 4'd1;
          if (idx_q == AnswerLastIdx) begin
            burst_d = BU_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      burst_q     <= BU_IDLE;
      idx_q       <= '0;
      hdr_abort_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      burst_q     <= burst_d;
      idx_q       <= idx_d;
      hdr_abort_q <= hdr_abort_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    out_last_q  <= out_last_d;
    out_abort_q <= out_abort_d;
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tlast    = out_last_q;
  assign m_axis_tuser[0] = out_abort_q;

endmodule

[rtl/dns_query_redirect_responder.sv]
// ----------------------------------------------------------------------------
// dns_query_redirect_responder
// Answers each whole DNS query that fits with an A record for the set address.
// ----------------------------------------------------------------------------
// The query datagram enters on the slave stream one byte per request, with
// tlast on its final byte. The response leaves on the master stream one byte
// per request, tlast on its final byte and tuser[0] set on an abort item,
// which tells the receiver to drop everything already sent for the datagram.
// The answer address is written through cfg_wr_en_i / cfg_wr_data_i; the user
// writes it while the block is idle, which the block itself does not enforce; reset loads 192.168.4.1.
// A name, type or class byte is loaded into the output register as it is
// accepted and appears on the master side in the next cycle; the header replay
// first passes through the burst sequencer. Name, type and class bytes flow at
// one byte per cycle while the receiver keeps up. After the twelfth header byte
// the input stalls while the header is replayed, and after the last class byte
// while the answer record is sent, since one output register serves both the
// pass-through and these bursts.
// Reset clears the parser to the header phase and empties the output.
// When the receiver stalls, the output register holds its item and
// s_axis_tready falls until that item is taken.
module dns_query_redirect_responder #(
  parameter int unsigned MaxPacketBytes = dqr_pkg::MaxPacketBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] query_byte
  input  logic        s_axis_tlast,   // query_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] reply_byte
  output logic        m_axis_tlast,   // reply_last
  output logic [0:0]  m_axis_tuser,   // [0] reply_abort
  input  logic        cfg_wr_en_i,
  input  logic [31:0] cfg_wr_data_i   // redirect_address
);
  import dqr_pkg::*;

  localparam int unsigned PosW = $clog2(MaxPacketBytes);

  phase_e          phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      label_q, label_d;
  logic [1:0]      trail_q, trail_d;
  logic [31:0]     redirect_address_q;

  emit_req_t       req;
  logic            emit_ready;
  logic            accept;
  logic            overrun;
  logic [7:0]      b;
  logic            last;

  assign s_axis_tready = emit_ready;
  assign accept        = s_axis_tvalid && emit_ready;
  assign b             = s_axis_tdata;
  assign last          = s_axis_tlast;

  // A response that would pass the size limit once the answer is added.
  assign overrun = (({1'b0, pos_q} + (PosW + 1)'(AnswerBytes + 1))
                    > (PosW + 1)'(MaxPacketBytes));

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      redirect_address_q <= RedirectAddressRst;
    end else if (cfg_wr_en_i) begin
      redirect_address_q <= cfg_wr_data_i;
    end
  end

  // Parser: one step per accepted query byte.
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    label_d = label_q;
    trail_d = trail_q;
    req     = '0;
    req.data      = b;
    req.store_idx = pos_q[3:0];

    if (accept) begin
      case (phase_q)
        PH_SWALLOW: begin
          if (last) begin
            phase_d = PH_HEADER;
            pos_d   = '0;
          end
        end
        PH_HEADER: begin
          req.store_we = 1'b1;
          if (pos_q < PosW'(HdrLastIdx)) begin
            pos_d = last ? '0 : pos_q + PosW'(1);
          end else begin
            req.start_hdr = 1'b1;
            req.hdr_abort = last;
            label_d       = '0;
            trail_d       = '0;
            if (last) begin
              pos_d = '0;
            end else begin
              pos_d   = PosW'(HdrBytes);
              phase_d = PH_NAME;
            end
          end
        end
        PH_NAME, PH_TRAILER: begin
          req.single = 1'b1;
          if (overrun || (last && !(phase_q == PH_TRAILER && trail_q == 2'd3))) begin
            // Abort item; restart, or swallow the rest of the datagram.
            req.data  = '0;
            req.last  = 1'b1;
            req.abort = 1'b1;
            pos_d     = '0;
            label_d   = '0;
            trail_d   = '0;
            phase_d   = last ? PH_HEADER : PH_SWALLOW;
          end else if (phase_q == PH_NAME) begin
            pos_d = pos_q + PosW'(1);
            if (label_q != '0) begin
              label_d = label_q - 8'd1;
            end else if (b == '0) begin
              phase_d = PH_TRAILER;
              trail_d = '0;
            end else begin
              label_d = b;
            end
          end else if (trail_q != 2'd3) begin
            trail_d = trail_q + 2'd1;
            pos_d   = pos_q + PosW'(1);
          end else begin
            // Last class byte: pass it and follow with the answer record.
            // The parser restarts at once if this byte ends the datagram.
            req.start_ans = 1'b1;
            pos_d         = '0;
            label_d       = '0;
            trail_d       = '0;
            phase_d       = last ? PH_HEADER : PH_SWALLOW;
          end
        end
        default: begin
          phase_d = PH_HEADER;
          pos_d   = '0;
        end
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= '0;
      label_q <= '0;
      trail_q <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      label_q <= label_d;
      trail_q <= trail_d;
    end
  end

  dqr_emitter u_emitter (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .req_i              (req),
    .redirect_address_i (redirect_address_q),
    .ready_o            (emit_ready),
    .m_axis_tvalid      (m_axis_tvalid),
    .m_axis_tready      (m_axis_tready),
    .m_axis_tdata       (m_axis_tdata),
    .m_axis_tlast       (m_axis_tlast),
    .m_axis_tuser       (m_axis_tuser)
  );

endmodule

[rtl/dqr_port_checker.sv]
// ----------------------------------------------------------------------------
// dqr_port_checker
// Port-level checks on the reply stream of the redirect responder.
// ----------------------------------------------------------------------------
module dqr_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [0:0] m_axis_tuser
);

  // A stalled reply item is held unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("reply item changed while stalled");

  // An abort item always closes the response.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("abort item without last");

  // An abort item carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 8'h00)
    else $error("abort item with non-zero byte");

  // No query byte is taken while a reply item waits on a stalled receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("query accepted while reply stalled");

endmodule

bind dns_query_redirect_responder dqr_port_checker u_dqr_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DNS query redirect responder.
// ----------------------------------------------------------------------------
// Query datagrams are fed in byte by byte on the slave stream. Each accepted
// request is also handed to a tracker that follows the parser state and
// queues the response bytes the block should send. Every byte taken from the
// master stream is checked against the oldest queued byte. The answer address
// is changed between phases, both streams stall at random, and the receiver
// holds off once for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------

import dqr_pkg::*;

// One response byte as it leaves the block.
typedef struct packed {
  logic [7:0] data;
  logic       last;
  logic       abort;
} reply_byte_t;

// Follows the responder's parsing and holds the response bytes still owed.
class dns_reply_tracker;
  int unsigned  max_bytes;
  logic [7:0]   hdr_store [HdrBytes];
  logic [9:0]   pos;
  phase_e       phase;
  logic [7:0]   label_left;
  logic [2:0]   trailer_seen;
  logic [31:0]  address;
  reply_byte_t  pending_replies [$];
  int           n_errors;
  int           n_replies;

  function new(int unsigned limit_bytes);
    max_bytes = limit_bytes;
    foreach (hdr_store[i]) hdr_store[i] = 8'h00;
    address   = RedirectAddressRst;
    n_errors  = 0;
    n_replies = 0;
    restart();
  endfunction

  function void restart();
    pos          = '0;
    phase        = PH_HEADER;
    label_left   = '0;
    trailer_seen = '0;
  endfunction

  function void set_address(logic [31:0] value);
    address = value;
  endfunction

  function void owe(logic [7:0] data, logic last, logic abort);
    reply_byte_t r;
    r.data  = data;
    r.last  = last;
    r.abort = abort;
    pending_replies.push_back(r);
  endfunction

  // Advance the parser by one accepted query byte and queue what it causes.
  function void note_query_byte(logic [7:0] b, logic lst);
    logic [7:0] h;
    case (phase)
      PH_SWALLOW: begin
        if (lst) restart();
      end
      PH_HEADER: begin
        hdr_store[pos[3:0]] = b;
        if (pos < 10'(HdrLastIdx)) begin
          if (lst) restart();
          else pos = pos + 10'd1;
        end else begin
          // Header complete: replay it with the flags and answer count fixed.
          for (int i = 0; i < HdrBytes; i++) begin
            h = hdr_store[i];
            if (i == HdrFlagsHiIdx || i == HdrFlagsLoIdx) h = h | HdrFlagBit;
            if (i == HdrAnCountLoIdx) h = 8'd1;
            owe(h, 1'b0, 1'b0);
          end
          if (lst) begin
            owe(8'h00, 1'b1, 1'b1);
            restart();
          end else begin
            pos          = 10'(HdrBytes);
            phase        = PH_NAME;
            label_left   = '0;
            trailer_seen = '0;
          end
        end
      end
      default: begin
        if (32'(pos) + 1 + AnswerBytes > max_bytes) begin
          // The answer would not fit in the datagram.
          owe(8'h00, 1'b1, 1'b1);
          restart();
          if (!lst) phase = PH_SWALLOW;
        end else if (lst && !(phase == PH_TRAILER && trailer_seen == 3'd3)) begin
          // Query cut short before its last class byte.
          owe(8'h00, 1'b1, 1'b1);
          restart();
        end else if (phase == PH_NAME) begin
          if (label_left != 8'd0) begin
            label_left = label_left - 8'd1;
          end else if (b == 8'd0) begin
            phase        = PH_TRAILER;
            trailer_seen = '0;
          end else begin
            label_left = b;
          end
          owe(b, 1'b0, 1'b0);
          pos = pos + 10'd1;
        end else if (trailer_seen < 3'd3) begin
          trailer_seen = trailer_seen + 3'd1;
          owe(b, 1'b0, 1'b0);
          pos = pos + 10'd1;
        end else begin
          // Last class byte, then the fixed answer record and the address.
          owe(b, 1'b0, 1'b0);
          for (int i = 0; i < AnswerPrefixBytes; i++) owe(AnswerPrefix[i], 1'b0, 1'b0);
          owe(address[31:24], 1'b0, 1'b0);
          owe(address[23:16], 1'b0, 1'b0);
          owe(address[15:8], 1'b0, 1'b0);
          owe(address[7:0], 1'b1, 1'b0);
          restart();
          if (!lst) phase = PH_SWALLOW;
        end
      end
    endcase
  endfunction

  task report_mismatch(string msg);
    n_errors++;
    $display("tb_top: mismatch: %s", msg);
  endtask

  // Compare one response byte with the oldest one owed.
  task check_reply_byte(logic [7:0] data, logic last, logic abort);
    reply_byte_t want;
    n_replies++;
    if (pending_replies.size() == 0) begin
      report_mismatch($sformatf("reply %0d (%h last %b abort %b) with none owed",
                                n_replies, data, last, abort));
    end else begin
      want = pending_replies.pop_front();
      if (data !== want.data)
        report_mismatch($sformatf("reply %0d byte %h, want %h", n_replies, data, want.data));
      if (last !== want.last)
        report_mismatch($sformatf("reply %0d last %b, want %b", n_replies, last, want.last));
      if (abort !== want.abort)
        report_mismatch($sformatf("reply %0d abort %b, want %b", n_replies, abort, want.abort));
    end
  endtask
endclass

module tb_top;

  localparam int unsigned MaxBytes    = MaxPacketBytesDef;
  localparam int          DrainCycles = 20;
  localparam int          HoldCycles  = 300;
  localparam int          PhaseBytes  = 75;

  typedef enum {Q_WELL, Q_POINTER, Q_EARLY, Q_SHORT, Q_HDR_ONLY, Q_NOISE} query_kind_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;
  logic        cfg_wr_en_i;
  logic [31:0] cfg_wr_data_i;

  dns_reply_tracker tracker;
  logic [7:0]       query_q [$];
  int               sent_bytes;
  logic             src_idle;
  logic             sink_idle;
  logic             hold_req;
  logic [31:0]      addr_list [4];

  dns_query_redirect_responder #(
    .MaxPacketBytes(MaxBytes)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // Watch both streams: note each accepted request, check each reply byte.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      tracker.note_query_byte(s_axis_tdata, s_axis_tlast);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_reply_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(sink_idle && $urandom_range(99, 0) < 15);
      end
    end
  end

  function automatic void add_random(int n);
    repeat (n) query_q.push_back(8'($urandom));
  endfunction

  function automatic void add_label(int len);
    query_q.push_back(8'(len));
    add_random(len);
  endfunction

  // Name of exactly n bytes, root label included; n must not be 2.
  function automatic void add_name_exact(int n);
    int rem;
    int len;
    rem = n - 1;
    while (rem > 0) begin
      len = (rem - 1 > 63) ? 63 : rem - 1;
      if (rem - (len + 1) == 1) len--;
      add_label(len);
      rem -= len + 1;
    end
    query_q.push_back(8'h00);
  endfunction

  function automatic void trim_query(int n);
    while (query_q.size() > n) void'(query_q.pop_back());
  endfunction

  function automatic query_kind_e pick_kind();
    int r;
    r = $urandom_range(99, 0);
    if (r < 55) return Q_WELL;
    if (r < 63) return Q_POINTER;
    if (r < 73) return Q_EARLY;
    if (r < 81) return Q_SHORT;
    if (r < 87) return Q_HDR_ONLY;
    return Q_NOISE;
  endfunction

  function automatic void build_query(query_kind_e kind);
    query_q.delete();
    case (kind)
      Q_SHORT:    add_random($urandom_range(HdrBytes - 1, 1));
      Q_HDR_ONLY: add_random(HdrBytes);
      Q_NOISE:    add_random($urandom_range(40, HdrBytes + 1));
      default: begin
        add_random(HdrBytes);
        repeat ($urandom_range(3, 0)) add_label($urandom_range(15, 1));
        // A length byte in the pointer range is still taken as a length.
        if (kind == Q_POINTER) add_label($urandom_range(255, 192));
        query_q.push_back(8'h00);
        add_random(4);
        if (kind == Q_EARLY) trim_query($urandom_range(query_q.size() - 1, HdrBytes + 1));
        else add_random($urandom_range(4, 0));
      end
    endcase
  endfunction

  // Offer one request and wait until it is taken.
  task automatic send_byte(logic [7:0] b, logic lst);
    if (src_idle && $urandom_range(99, 0) < 15) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_query();
    foreach (query_q[i]) send_byte(query_q[i], i == query_q.size() - 1);
    sent_bytes += query_q.size();
  endtask

  // Stop offering and let every owed reply come out.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    // Wait on the clock first, so that the last accepted request has been noted.
    @(posedge clk_i);
    while (tracker.pending_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_address(logic [31:0] value);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    tracker.set_address(value);
  endtask

  // Queries whose question runs up to and past the size limit.
  task automatic send_long_queries();
    // Last class byte lands on the final position that still fits.
    query_q.delete();
    add_random(HdrBytes);
    add_name_exact(MaxBytes - AnswerBytes - HdrBytes - 4);
    add_random(4 + $urandom_range(3, 0));
    send_query();
    // Last class byte one past that, and also the final byte.
    query_q.delete();
    add_random(HdrBytes);
    add_name_exact(MaxBytes - AnswerBytes - HdrBytes - 3);
    add_random(4);
    send_query();
    // Name overruns and the datagram goes on for a while.
    query_q.delete();
    add_random(HdrBytes);
    add_name_exact(600);
    trim_query(MaxBytes + 9);
    send_query();
    // Name overruns on the final byte itself.
    query_q.delete();
    add_random(HdrBytes);
    add_name_exact(600);
    trim_query(MaxBytes - AnswerBytes + 1);
    send_query();
  endtask

  initial begin : stimulus
    int kinds_seen;
    tracker       = new(MaxBytes);
    sent_bytes    = 0;
    src_idle      = 1'b1;
    sink_idle     = 1'b1;
    hold_req      = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    cfg_wr_en_i   <= 1'b0;
    cfg_wr_data_i <= 32'h0;
    addr_list[0] = 32'h0000_0000;
    addr_list[1] = 32'hFFFF_FFFF;
    addr_list[2] = $urandom;
    addr_list[3] = $urandom;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a one-byte datagram, a header-only datagram, a minimal query.
    query_q.delete();
    query_q.push_back(8'hFF);
    send_query();
    query_q.delete();
    for (int i = 0; i < HdrBytes; i++) query_q.push_back((i % 2) ? 8'hFF : 8'h00);
    send_query();
    query_q.delete();
    repeat (HdrBytes) query_q.push_back(8'hFF);
    query_q.push_back(8'h00);
    query_q.push_back(8'h00);
    query_q.push_back(8'hFF);
    query_q.push_back(8'h00);
    query_q.push_back(8'hFF);
    send_query();

    // Random phases, each with its own answer address.
    kinds_seen = 0;
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_address(addr_list[ph]);
      src_idle  = (ph != 1);
      sink_idle = (ph != 1);
      if (ph == 0) hold_req = 1'b1;
      sent_bytes = 0;
      while (sent_bytes < PhaseBytes) begin
        if (kinds_seen <= Q_NOISE) begin
          build_query(query_kind_e'(kinds_seen));
          kinds_seen++;
        end else begin
          build_query(pick_kind());
        end
        send_query();
      end
      if (ph == 2) send_long_queries();
    end

    settle();
    if (tracker.pending_replies.size() != 0)
      tracker.report_mismatch($sformatf("%0d replies never arrived",
                                        tracker.pending_replies.size()));
    if (tracker.n_errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
